// ----- rtl/soab_pkg.sv -----
// Shared types, constants and the div255 helper function for the straight-alpha over blend core.
// Used by every module in rtl/ except soab_chk, and by verif/; depends on nothing else.
package soab_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned ProdW    = 2 * ChanW;
	localparam int unsigned NumW     = ProdW + 1;
	localparam int unsigned DivStages = 4;
	localparam int unsigned BitsPerDiv = ChanW / DivStages;
	localparam logic [ChanW-1:0] FullAlpha = 8'd255;

	typedef enum logic [1:0] {
		SEL_TOP   = 2'd0,
		SEL_UNDER = 2'd1,
		SEL_BLEND = 2'd2
	} sel_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
	} pixel_t;

	// after the coverage product
	typedef struct packed {
		sel_t             sel;
		pixel_t           top;
		pixel_t           under;
		logic [ProdW-1:0] prod;
	} frac_t;

	// after the under coverage and output alpha
	typedef struct packed {
		sel_t             sel;
		pixel_t           top;
		pixel_t           under;
		logic [ChanW-1:0] ua;
		logic [ChanW-1:0] alpha;
	} cov_t;

	// one beat in the divider: per-channel remainder and partial quotient
	typedef struct packed {
		sel_t                        sel;
		pixel_t                      pass;
		logic [ChanW-1:0]            alpha;
		logic [2:0][NumW-1:0]        rem;
		logic [2:0][ChanW-1:0]       quo;
	} div_t;

	// floor(x/255), exact for any x below 65280
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] sum;
		sum = {1'b0, x} + NumW'(1) + NumW'(x[ProdW-1:ChanW]);
		return sum[ProdW-1:ChanW];
	endfunction

endpackage

// ----- rtl/soab_alpha.sv -----
// First pipeline stage: classify the pixel pair and form under_alpha*(255-top_alpha).
// Depends on soab_pkg.
module soab_alpha (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  soab_pkg::pixel_t   top,
	input  soab_pkg::pixel_t   under,
	input  logic               next_ready,
	output logic               valid_s1,
	output soab_pkg::frac_t    data_s1
);

	soab_pkg::frac_t nxt;

	assign ready = !valid_s1 || next_ready;

	always_comb begin
		nxt.top   = top;
		nxt.under = under;
		nxt.prod  = soab_pkg::ProdW'(under.alpha) *
			soab_pkg::ProdW'(soab_pkg::FullAlpha - top.alpha);
		// opaque top wins even over a transparent under
		if (top.alpha == soab_pkg::FullAlpha || under.alpha == '0) begin
			nxt.sel = soab_pkg::SEL_TOP;
		end else if (top.alpha == '0) begin
			nxt.sel = soab_pkg::SEL_UNDER;
		end else begin
			nxt.sel = soab_pkg::SEL_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- rtl/soab_mac.sv -----
// Second and third pipeline stages: under coverage, output alpha and the rounded
// per-channel numerators t*ta + u*ua + alpha/2. Depends on soab_pkg.
module soab_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  soab_pkg::frac_t    data,
	input  logic               next_ready,
	output logic               valid_s3,
	output soab_pkg::div_t     data_s3
);

	logic              valid_s2;
	logic              rdy_s2;
	logic              rdy_s3;
	soab_pkg::cov_t    data_s2;
	soab_pkg::cov_t    cov_nxt;
	soab_pkg::div_t    div_nxt;
	logic [2:0][soab_pkg::ChanW-1:0] top_c;
	logic [2:0][soab_pkg::ChanW-1:0] under_c;

	assign rdy_s3 = !valid_s3 || next_ready;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign ready  = rdy_s2;

	always_comb begin
		cov_nxt.sel   = data.sel;
		cov_nxt.top   = data.top;
		cov_nxt.under = data.under;
		cov_nxt.ua    = soab_pkg::div255(data.prod);
		cov_nxt.alpha = data.top.alpha + cov_nxt.ua;
	end

	assign top_c   = {data_s2.top.blue, data_s2.top.green, data_s2.top.red};
	assign under_c = {data_s2.under.blue, data_s2.under.green, data_s2.under.red};

	always_comb begin
		div_nxt.sel   = data_s2.sel;
		div_nxt.alpha = data_s2.alpha;
		div_nxt.pass  = (data_s2.sel == soab_pkg::SEL_UNDER) ? data_s2.under : data_s2.top;
		div_nxt.quo   = '0;
		for (int c = 0; c < 3; c++) begin
			div_nxt.rem[c] =
				soab_pkg::NumW'(soab_pkg::ProdW'(top_c[c]) *
					soab_pkg::ProdW'(data_s2.top.alpha)) +
				soab_pkg::NumW'(soab_pkg::ProdW'(under_c[c]) *
					soab_pkg::ProdW'(data_s2.ua)) +
				soab_pkg::NumW'(data_s2.alpha >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= valid;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid) begin
			data_s2 <= cov_nxt;
		end
		if (rdy_s3 && valid_s2) begin
			data_s3 <= div_nxt;
		end
	end

endmodule

// ----- rtl/soab_div.sv -----
// One divider stage: resolves BitsPerDiv quotient bits of numerator/alpha for all
// three channels by restoring compare and subtract. Depends on soab_pkg.
module soab_div #(
	parameter int unsigned HiBit = soab_pkg::ChanW - 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  soab_pkg::div_t     data,
	input  logic               next_ready,
	output logic               valid_s1,
	output soab_pkg::div_t     data_s1
);

	soab_pkg::div_t             nxt;
	logic [soab_pkg::NumW-1:0]  dvs;

	assign ready = !valid_s1 || next_ready;

	always_comb begin
		nxt = data;
		dvs = '0;
		for (int k = 0; k < soab_pkg::BitsPerDiv; k++) begin
			dvs = soab_pkg::NumW'(data.alpha) << (HiBit - k);
			for (int c = 0; c < 3; c++) begin
				if (nxt.rem[c] >= dvs) begin
					nxt.rem[c] = nxt.rem[c] - dvs;
					nxt.quo[c][HiBit - k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- rtl/straight_alpha_over_blend_core.sv -----
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | top_red..top_alpha, under_red..under_alpha
// out     | out | out_valid/out_stall | out_red, out_green, out_blue, out_alpha
// Seven register stages: classify and coverage product, coverage divide by 255,
// channel numerators, then four divider stages of two quotient bits each.
// One pixel per clock while out_stall is low; an accepted beat passes the stages in
// the order above, and out_valid is the valid bit of the last divider stage.
// Reset clears only the stage valid bits. Every stage holds its beat while the one
// after it is full and stalled, so empty stages fill even while out_stall is high.
// Top level of the straight-alpha over blend core; depends on soab_pkg, soab_alpha,
// soab_mac and soab_div.
module straight_alpha_over_blend_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] top_red,
	input  logic [7:0] top_green,
	input  logic [7:0] top_blue,
	input  logic [7:0] top_alpha,
	input  logic [7:0] under_red,
	input  logic [7:0] under_green,
	input  logic [7:0] under_blue,
	input  logic [7:0] under_alpha,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha
);

	localparam int unsigned N = soab_pkg::DivStages;

	soab_pkg::pixel_t top;
	soab_pkg::pixel_t under;
	logic             rdy_in;
	logic             valid_s1;
	logic             rdy_s1;
	soab_pkg::frac_t  data_s1;
	logic             valid_s3;
	logic             rdy_s3;
	soab_pkg::div_t   data_s3;

	logic [N:0]            dv_valid;
	logic [N:0]            dv_rdy;
	soab_pkg::div_t [N:0]  dv_data;
	soab_pkg::div_t        last;

	assign top   = '{red: top_red, green: top_green, blue: top_blue, alpha: top_alpha};
	assign under = '{red: under_red, green: under_green, blue: under_blue,
		alpha: under_alpha};

	assign in_stall = !rdy_in;

	soab_alpha u_alpha (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (in_valid),
		.ready      (rdy_in),
		.top        (top),
		.under      (under),
		.next_ready (rdy_s1),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	soab_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.ready      (rdy_s1),
		.data       (data_s1),
		.next_ready (rdy_s3),
		.valid_s3   (valid_s3),
		.data_s3    (data_s3)
	);

	assign dv_valid[0] = valid_s3;
	assign dv_data[0]  = data_s3;
	assign rdy_s3      = dv_rdy[0];

	for (genvar i = 0; i < N; i++) begin : g_div
		soab_div #(
			.HiBit (soab_pkg::ChanW - 1 - i * soab_pkg::BitsPerDiv)
		) u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid      (dv_valid[i]),
			.ready      (dv_rdy[i]),
			.data       (dv_data[i]),
			.next_ready (dv_rdy[i+1]),
			.valid_s1   (dv_valid[i+1]),
			.data_s1    (dv_data[i+1])
		);
	end

	assign dv_rdy[N]  = !out_stall;
	assign out_valid  = dv_valid[N];
	assign last       = dv_data[N];

	always_comb begin
		if (last.sel == soab_pkg::SEL_BLEND) begin
			out_red   = last.quo[0];
			out_green = last.quo[1];
			out_blue  = last.quo[2];
			out_alpha = last.alpha;
		end else begin
			out_red   = last.pass.red;
			out_green = last.pass.green;
			out_blue  = last.pass.blue;
			out_alpha = last.pass.alpha;
		end
	end

endmodule

// ----- rtl/soab_chk.sv -----
// Port-level checker for the straight-alpha over blend core, bound to the top level.
// Depends only on the top level's ports.
module soab_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] top_red,
	input logic [7:0] top_green,
	input logic [7:0] top_blue,
	input logic [7:0] top_alpha,
	input logic [7:0] under_red,
	input logic [7:0] under_green,
	input logic [7:0] under_blue,
	input logic [7:0] under_alpha,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
			$stable(out_blue) && $stable(out_alpha))
		else $error("stalled output beat changed");

	// input backpressure only when every stage is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an accepted beat reaches the output when nothing stalls it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
			##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted beat did not arrive after seven cycles");

endmodule

bind straight_alpha_over_blend_core soab_chk u_soab_chk (.*);

// ----- verif/soab_over_checker.sv -----
// Checker for the straight-alpha over blend core: watches both channels, predicts each
// composited pixel and compares it with what comes out. Depends on soab_pkg.
module soab_over_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  soab_pkg::pixel_t top_pix,
	input  soab_pkg::pixel_t under_pix,
	input  logic             out_valid,
	input  logic             out_stall,
	input  soab_pkg::pixel_t out_pix,
	output int               mismatch_count,
	output int               pending
);

	soab_pkg::pixel_t pending_composites[$];

	function automatic logic [soab_pkg::ChanW-1:0] mix_chan(input int unsigned t,
			input int unsigned u, input int unsigned ta, input int unsigned cov,
			input int unsigned sum_a);
		return soab_pkg::ChanW'((t * ta + u * cov + (sum_a >> 1)) / sum_a);
	endfunction

	function automatic soab_pkg::pixel_t compose_over(input soab_pkg::pixel_t t,
			input soab_pkg::pixel_t u);
		int unsigned full;
		int unsigned ta;
		int unsigned cov;
		int unsigned sum_a;
		soab_pkg::pixel_t res;
		full = soab_pkg::FullAlpha;
		ta = t.alpha;
		// opaque top wins even over a transparent under, so test it first
		if (t.alpha == soab_pkg::FullAlpha || u.alpha == '0)
			return t;
		if (t.alpha == '0)
			return u;
		cov = (int'(u.alpha) * (full - ta)) / full;
		sum_a = ta + cov;
		res.red   = mix_chan(t.red, u.red, ta, cov, sum_a);
		res.green = mix_chan(t.green, u.green, ta, cov, sum_a);
		res.blue  = mix_chan(t.blue, u.blue, ta, cov, sum_a);
		res.alpha = soab_pkg::ChanW'(sum_a);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		soab_pkg::pixel_t want;
		if (!arst_n) begin
			pending_composites.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_composites.size() == 0) begin
					report_mismatch($sformatf("output beat %h with nothing expected", out_pix));
				end else begin
					want = pending_composites.pop_front();
					if (out_pix.red !== want.red)
						report_mismatch($sformatf("out_red %h, expected %h", out_pix.red, want.red));
					if (out_pix.green !== want.green)
						report_mismatch($sformatf("out_green %h, expected %h",
							out_pix.green, want.green));
					if (out_pix.blue !== want.blue)
						report_mismatch($sformatf("out_blue %h, expected %h",
							out_pix.blue, want.blue));
					if (out_pix.alpha !== want.alpha)
						report_mismatch($sformatf("out_alpha %h, expected %h",
							out_pix.alpha, want.alpha));
				end
			end
			// append the prediction for the accepted beat
			if (in_valid && !in_stall)
				pending_composites = {pending_composites, compose_over(top_pix, under_pix)};
		end
		pending = pending_composites.size();
	end

endmodule

// ----- verif/tb_straight_alpha_over_blend_core.sv -----
// Testbench top for the straight-alpha over blend core: clock, reset, pixel stimulus,
// random output stall and the verdict. Depends on soab_pkg, soab_over_checker and the core.
module tb_straight_alpha_over_blend_core;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] top_red = '0;
	logic [7:0] top_green = '0;
	logic [7:0] top_blue = '0;
	logic [7:0] top_alpha = '0;
	logic [7:0] under_red = '0;
	logic [7:0] under_green = '0;
	logic [7:0] under_blue = '0;
	logic [7:0] under_alpha = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	int mismatch_count;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	straight_alpha_over_blend_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.top_red     (top_red),
		.top_green   (top_green),
		.top_blue    (top_blue),
		.top_alpha   (top_alpha),
		.under_red   (under_red),
		.under_green (under_green),
		.under_blue  (under_blue),
		.under_alpha (under_alpha),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_alpha   (out_alpha)
	);

	soab_over_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.top_pix        ({top_red, top_green, top_blue, top_alpha}),
		.under_pix      ({under_red, under_green, under_blue, under_alpha}),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_pix        ({out_red, out_green, out_blue, out_alpha}),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [7:0] random_chan();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// lean on the pass-through cases and the alphas next to them
	function automatic logic [7:0] random_alpha();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return soab_pkg::FullAlpha;
			2:       return 8'($urandom_range(1, 3));
			3:       return 8'($urandom_range(252, 254));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [63:0] random_beat();
		return {random_chan(), random_chan(), random_chan(), random_alpha(),
			random_chan(), random_chan(), random_chan(), random_alpha()};
	endfunction

	// called at a rising edge; returns at the edge that accepts the beat
	task automatic send_pixel(input logic [63:0] beat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{top_red, top_green, top_blue, top_alpha} <= beat[63:32];
		{under_red, under_green, under_blue, under_alpha} <= beat[31:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold the sender off until every composite is back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_pixel(random_beat());
	endtask

	logic [63:0] directed_beats[] = '{
		64'hffffffff_ffffffff, // opaque over opaque
		64'h00000000_00000000, // both transparent
		64'h112233ff_44556600, // opaque top, transparent under
		64'h11223300_44556600, // transparent top and under: top passes
		64'h11223300_445566ff, // transparent top: under passes
		64'h11223300_44556680,
		64'hffffff01_000000ff, // faintest top over opaque under
		64'h00000001_ffffffff,
		64'hfffffffe_00000001, // under coverage rounds down to zero
		64'h12345601_abcdef01, // smallest output alpha
		64'hffffff80_00000080,
		64'h00000080_ffffff80,
		64'hff00ff7f_00ff00ff,
		64'ha5a5a5fe_5a5a5afe,
		64'h5a5a5a01_a5a5a501,
		64'hffffffff_00000000,
		64'h00000000_ffffff00,
		64'h80808040_7f7f7fc0
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_stall_pct = 68;
		foreach (directed_beats[i])
			send_pixel(directed_beats[i]);
		send_random(640);
		drain();

		send_idle_pct = 68;
		recv_stall_pct = 18;
		send_random(630);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(630);
		drain();

		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
